/* src/assert_macros.svh */
// Assertion macros shared by the pattern step sequencer RTL.
// Simulation builds get concurrent assertions clocked on clk and reset by arst_n.
// Synthesis builds get empty macro bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define PSS_ASSERT(label, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("assertion failed");

`define PSS_ASSERT_NEVER(label, expr) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) \
		else $error("forbidden condition seen");

`else

`define PSS_ASSERT(label, prop)

`define PSS_ASSERT_NEVER(label, expr)

`endif

`endif

/* src/pss_pkg.sv */
// Package for the pattern step sequencer: sizes, payload structs, codes and helpers.
// Used by every module of the block; depends on nothing else.

package pss_pkg;

	localparam int COLUMNS  = 32;
	localparam int ROWS     = 20;
	localparam int PATTERNS = 16;

	localparam int CELL_W      = 10;
	localparam int QUO_W       = 7;
	localparam int TS_W        = 32;
	localparam int NOTE_W      = 8;
	localparam int PAT_W       = 4;
	localparam int TRANSPOSE_W = 7;
	localparam int NOTE_LEN_W  = 20;
	localparam int COL_FIELD_W = 5;
	localparam int ROW_FIELD_W = 5;
	localparam int CFG_DATA_W  = 20;
	localparam int PROD_W      = QUO_W + NOTE_LEN_W;

	localparam int STORE_WORDS = PATTERNS * COLUMNS;
	localparam int ADDR_W      = (STORE_WORDS > 1) ? $clog2(STORE_WORDS) : 1;
	localparam int ROW_IDX_W   = (ROWS > 1) ? $clog2(ROWS) : 1;

	localparam int Q_DEPTH = 2;
	localparam int QP_W    = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
	localparam int QC_W    = $clog2(Q_DEPTH + 1);

	// Division by ten as a multiply by a reciprocal, exact for every 10-bit value.
	localparam int DIV10_MUL = 205;
	localparam int DIV10_SH  = 11;
	localparam int DIV10_P_W = CELL_W + 8;

	localparam logic [TRANSPOSE_W-1:0] TRANSPOSE_RESET = TRANSPOSE_W'(32);
	localparam logic [NOTE_LEN_W-1:0]  NOTE_LEN_RESET  = NOTE_LEN_W'(4410);

	typedef enum logic {
		REQ_WRITE = 1'b0,
		REQ_STEP  = 1'b1
	} req_type_t;

	typedef enum logic [1:0] {
		CFG_PLAY_PATTERN = 2'd0,
		CFG_EDIT_PATTERN = 2'd1,
		CFG_TRANSPOSE    = 2'd2,
		CFG_NOTE_LENGTH  = 2'd3
	} cfg_index_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_ON,
		BK_OFF
	} back_state_t;

	typedef struct packed {
		req_type_t                req_type;
		logic [COL_FIELD_W-1:0]   column;
		logic [ROW_FIELD_W-1:0]   row;
		logic [CELL_W-1:0]        cell_length;
		logic [TS_W-1:0]          timestamp;
	} in_item_t;

	typedef struct packed {
		logic                     note_off;
		logic [NOTE_W-1:0]        note_number;
		logic [TS_W-1:0]          event_time;
		logic                     last;
	} out_item_t;

	typedef struct packed {
		logic [PAT_W-1:0]         play_pattern;
		logic [PAT_W-1:0]         edit_pattern;
		logic [TRANSPOSE_W-1:0]   transpose;
		logic [NOTE_LEN_W-1:0]    note_length;
	} cfg_t;

	typedef logic [ROWS-1:0][CELL_W-1:0] col_word_t;

	typedef struct packed {
		col_word_t                cells;
		logic [TS_W-1:0]          timestamp;
	} qent_t;

	typedef struct packed {
		logic [QC_W-1:0]          count;
		logic                     empty;
	} q_status_t;

	function automatic logic [ADDR_W-1:0] store_addr(
		input logic [PAT_W-1:0]       pat,
		input logic [COL_FIELD_W-1:0] col
	);
		return ADDR_W'(int'(pat) * COLUMNS + int'(col));
	endfunction

	function automatic logic [QUO_W-1:0] div10(input logic [CELL_W-1:0] len);
		logic [DIV10_P_W-1:0] p;
		p = DIV10_P_W'(len) * DIV10_P_W'(DIV10_MUL);
		return QUO_W'(p >> DIV10_SH);
	endfunction

endpackage

/* src/pattern_step_sequencer_top.sv */
// Top level of the pattern step sequencer.
// Instantiates pss_front, pss_queue and pss_back; uses pss_pkg.
//
// Requests arrive on in_valid/in_ready with an in_item. A cell write stores one
// note length into the pattern chosen by edit_pattern and gives no result. A step
// request reads one column of the pattern chosen by play_pattern; for every row with
// a nonzero length, row 0 first, two results leave on out_valid/out_ready: a note-on
// at the step time and a note-off at time + (length/10) * note_length, with last set
// on the final one. Registers are written on cfg_valid/cfg_ready, which is always
// ready; the user must write them only while no step is still in progress, and the
// block itself does not enforce this. A write is stored when it is accepted.
// A step reads its column word into a registered stage that pushes it into the
// queue; the back part pops it while idle, then alternates note-on and note-off
// states and emits one result per cycle while the receiver keeps out_ready high.
// The back part takes the next queued column only once it is idle again.
// The two-entry queue lets up to two read steps wait while the back part works.
// After reset the pattern store is cleared one column word per cycle, covering all
// PATTERNS * COLUMNS = 512 words with in_ready low. When the receiver stalls, the
// result holds in the output register and the queue fills, then in_ready drops.

module pattern_step_sequencer_top (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  pss_pkg::in_item_t                  in_item,
	output logic                               out_valid,
	input  logic                               out_ready,
	output pss_pkg::out_item_t                 out_item,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  pss_pkg::cfg_index_t                cfg_index,
	input  logic [pss_pkg::CFG_DATA_W-1:0]     cfg_data
);
	import pss_pkg::*;

	q_status_t q_stat;
	logic      q_push;
	qent_t     q_data;
	logic      q_pop;
	qent_t     q_head;
	cfg_t      cfg;

	pss_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_item   (in_item),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.q_stat    (q_stat),
		.q_push    (q_push),
		.q_data    (q_data),
		.cfg       (cfg)
	);

	pss_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_data),
		.pop       (q_pop),
		.head      (q_head),
		.status    (q_stat)
	);

	pss_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (q_head),
		.q_stat    (q_stat),
		.q_pop     (q_pop),
		.cfg       (cfg),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item)
	);

endmodule

/* src/pss_queue.sv */
// Short request queue between the front and back parts of the step sequencer.
// Holds column words read from the pattern store with their step times; uses pss_pkg.

module pss_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  pss_pkg::qent_t    push_data,
	input  logic              pop,
	output pss_pkg::qent_t    head,
	output pss_pkg::q_status_t status
);
	import pss_pkg::*;

	qent_t           ent_q [Q_DEPTH];
	logic [QP_W-1:0] wr_ptr_q;
	logic [QP_W-1:0] rd_ptr_q;
	logic [QC_W-1:0] count_q;
	logic            do_pop;

	assign do_pop = pop && (count_q != '0);

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (int'(wr_ptr_q) == Q_DEPTH - 1) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (int'(rd_ptr_q) == Q_DEPTH - 1) ? '0 : rd_ptr_q + 1'b1;
			end
			unique case ({push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	assign head         = ent_q[rd_ptr_q];
	assign status.count = count_q;
	assign status.empty = (count_q == '0);

endmodule

/* src/pss_front.sv */
// Front part of the step sequencer: request intake, configuration registers,
// pattern store with its clearing pass, and column reads into the queue. Uses pss_pkg.

`include "assert_macros.svh"

module pss_front (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  pss_pkg::in_item_t                  in_item,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  pss_pkg::cfg_index_t                cfg_index,
	input  logic [pss_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  pss_pkg::q_status_t                 q_stat,
	output logic                               q_push,
	output pss_pkg::qent_t                     q_data,
	output pss_pkg::cfg_t                      cfg
);
	import pss_pkg::*;

	col_word_t         mem [STORE_WORDS];
	cfg_t              cfg_q;
	logic              clr_busy_q;
	logic [ADDR_W-1:0] clr_addr_q;
	logic              rd_valid_s1;
	col_word_t         rd_word_s1;
	logic [TS_W-1:0]   ts_s1;
	logic              accept;
	logic              step_ok;
	logic              wr_ok;
	logic [ADDR_W-1:0] waddr;
	logic [ADDR_W-1:0] raddr;
	logic [QC_W:0]     q_used;

	assign cfg_ready = 1'b1;
	assign q_used    = {1'b0, q_stat.count} + (QC_W + 1)'(rd_valid_s1);
	assign in_ready  = !clr_busy_q && (q_used < (QC_W + 1)'(Q_DEPTH));
	assign accept    = in_valid && in_ready;

	assign step_ok = (in_item.req_type == REQ_STEP) && (int'(in_item.column) < COLUMNS)
		&& (int'(cfg_q.play_pattern) < PATTERNS);
	assign wr_ok = (in_item.req_type == REQ_WRITE) && (int'(in_item.column) < COLUMNS)
		&& (int'(in_item.row) < ROWS) && (int'(cfg_q.edit_pattern) < PATTERNS);

	assign waddr = store_addr(cfg_q.edit_pattern, in_item.column);
	assign raddr = store_addr(cfg_q.play_pattern, in_item.column);

	always_ff @(posedge clk) begin
		if (clr_busy_q) begin
			mem[clr_addr_q] <= '0;
		end else if (accept && wr_ok) begin
			mem[waddr][in_item.row[ROW_IDX_W-1:0]] <= in_item.cell_length;
		end
		if (accept && step_ok) begin
			rd_word_s1 <= mem[raddr];
			ts_s1      <= in_item.timestamp;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q  <= 1'b1;
			clr_addr_q  <= '0;
			rd_valid_s1 <= 1'b0;
		end else begin
			if (clr_busy_q) begin
				clr_addr_q <= clr_addr_q + 1'b1;
				if (clr_addr_q == ADDR_W'(STORE_WORDS - 1)) begin
					clr_busy_q <= 1'b0;
				end
			end
			rd_valid_s1 <= accept && step_ok;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.play_pattern <= '0;
			cfg_q.edit_pattern <= '0;
			cfg_q.transpose    <= TRANSPOSE_RESET;
			cfg_q.note_length  <= NOTE_LEN_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_PLAY_PATTERN: cfg_q.play_pattern <= cfg_data[PAT_W-1:0];
				CFG_EDIT_PATTERN: cfg_q.edit_pattern <= cfg_data[PAT_W-1:0];
				CFG_TRANSPOSE:    cfg_q.transpose    <= cfg_data[TRANSPOSE_W-1:0];
				CFG_NOTE_LENGTH:  cfg_q.note_length  <= cfg_data[NOTE_LEN_W-1:0];
			endcase
		end
	end

	assign q_push          = rd_valid_s1;
	assign q_data.cells    = rd_word_s1;
	assign q_data.timestamp = ts_s1;
	assign cfg             = cfg_q;

	`PSS_ASSERT_NEVER(a_no_accept_in_clear, clr_busy_q && in_ready)
	`PSS_ASSERT_NEVER(a_no_push_when_full, rd_valid_s1 && (int'(q_stat.count) == Q_DEPTH))
	`PSS_ASSERT(a_read_follows_step,
		rd_valid_s1 |-> $past(in_valid && in_ready && (in_item.req_type == REQ_STEP)))

endmodule

/* src/pss_back.sv */
// Back part of the step sequencer: scans one queued column word and emits note-on and
// note-off results through an output register. Uses pss_pkg.

`include "assert_macros.svh"

module pss_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  pss_pkg::qent_t        head,
	input  pss_pkg::q_status_t    q_stat,
	output logic                  q_pop,
	input  pss_pkg::cfg_t         cfg,
	output logic                  out_valid,
	input  logic                  out_ready,
	output pss_pkg::out_item_t    out_item
);
	import pss_pkg::*;

	back_state_t          state_q;
	back_state_t          state_d;
	logic [ROWS-1:0]      mask_q;
	col_word_t            cells_q;
	logic [TS_W-1:0]      ts_q;
	logic [ROW_IDX_W-1:0] row_q;
	logic [QUO_W-1:0]     quo_q;
	logic                 out_valid_q;
	out_item_t            out_q;
	logic [ROWS-1:0]      head_mask;
	logic [ROW_IDX_W-1:0] pick;
	logic                 slot_free;
	logic                 emit;
	out_item_t            emit_item;
	logic [PROD_W-1:0]    prod;

	assign slot_free = !out_valid_q || out_ready;

	always_comb begin
		for (int i = 0; i < ROWS; i++) begin
			head_mask[i] = |head.cells[i];
		end
	end

	always_comb begin
		pick = '0;
		for (int i = ROWS - 1; i >= 0; i--) begin
			if (mask_q[i]) begin
				pick = ROW_IDX_W'(i);
			end
		end
	end

	assign prod = PROD_W'(quo_q) * PROD_W'(cfg.note_length);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			BK_IDLE: begin
				if (!q_stat.empty && (head_mask != '0)) begin
					state_d = BK_ON;
				end
			end
			BK_ON: begin
				if (slot_free) begin
					state_d = BK_OFF;
				end
			end
			BK_OFF: begin
				if (slot_free) begin
					state_d = (mask_q == '0) ? BK_IDLE : BK_ON;
				end
			end
			default: state_d = BK_IDLE;
		endcase
	end

	always_comb begin
		q_pop     = 1'b0;
		emit      = 1'b0;
		emit_item = '0;
		unique case (state_q)
			BK_IDLE: begin
				q_pop = !q_stat.empty;
			end
			BK_ON: begin
				emit                  = slot_free;
				emit_item.note_off    = 1'b0;
				emit_item.note_number = NOTE_W'(pick) + NOTE_W'(cfg.transpose);
				emit_item.event_time  = ts_q;
				emit_item.last        = 1'b0;
			end
			BK_OFF: begin
				emit                  = slot_free;
				emit_item.note_off    = 1'b1;
				emit_item.note_number = NOTE_W'(row_q) + NOTE_W'(cfg.transpose);
				emit_item.event_time  = ts_q + TS_W'(prod);
				emit_item.last        = (mask_q == '0);
			end
			default: begin
				q_pop = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			cells_q <= head.cells;
			ts_q    <= head.timestamp;
		end
		if ((state_q == BK_ON) && slot_free) begin
			row_q <= pick;
			quo_q <= div10(cells_q[pick]);
		end
		if (emit) begin
			out_q <= emit_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_IDLE;
			mask_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (q_pop) begin
				mask_q <= head_mask;
			end else if ((state_q == BK_ON) && slot_free) begin
				mask_q[pick] <= 1'b0;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_q;

	`PSS_ASSERT(a_last_is_off, out_valid_q && out_q.last |-> out_q.note_off)
	`PSS_ASSERT(a_on_has_row, (state_q == BK_ON) |-> (mask_q != '0))
	`PSS_ASSERT(a_off_after_on,
		(state_q == BK_OFF) |-> (($past(state_q) == BK_ON) || ($past(state_q) == BK_OFF)))

endmodule

/* test/pattern_step_sequencer_top_tb.sv */
// Self-checking testbench for pattern_step_sequencer_top: cell writes and step requests,
// with every note-on and note-off predicted and compared field by field.
// Depends on pss_pkg and the pattern_step_sequencer_top RTL.

module pattern_step_sequencer_top_tb;
	import pss_pkg::*;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  in_valid  = 1'b0;
	logic                  in_ready;
	in_item_t              in_item   = '0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	out_item_t             out_item;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	cfg_index_t            cfg_index = CFG_PLAY_PATTERN;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;

	pattern_step_sequencer_top i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #6 clk = ~clk;

	in_item_t          request_fifo[$];
	out_item_t         note_events[$];
	logic [CELL_W-1:0] grid[PATTERNS][COLUMNS][ROWS];
	cfg_t              shadow_cfg;
	logic              in_fire_q;
	logic              cfg_fire_q;
	int                requests_queued = 0;
	int                requests_taken;
	int                err_count = 0;
	int                burst_left = 0;
	int                gap_left = 0;
	int                sink_cycle = 0;

	task automatic queue_request(input req_type_t kind, input logic [COL_FIELD_W-1:0] col,
			input logic [ROW_FIELD_W-1:0] row, input logic [CELL_W-1:0] len,
			input logic [TS_W-1:0] stamp);
		in_item_t rq;
		rq.req_type    = kind;
		rq.column      = col;
		rq.row         = row;
		rq.cell_length = len;
		rq.timestamp   = stamp;
		request_fifo.push_back(rq);
		requests_queued++;
	endtask

	function automatic logic [CELL_W-1:0] rand_length();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return CELL_W'($urandom_range(1, 9));
			2: return '1;
			default: return CELL_W'($urandom_range(0, 1023));
		endcase
	endfunction

	function automatic logic [TS_W-1:0] rand_stamp();
		if ($urandom_range(0, 5) == 0)
			return 32'hFFFF_FFFF - TS_W'($urandom_range(0, 2000000));
		return TS_W'($urandom);
	endfunction

	// Cell writes update the shadow store; steps queue the note-on/note-off pairs.
	task automatic apply_request(input in_item_t rq);
		int                last_row;
		logic [CELL_W-1:0] len;
		out_item_t         ev;
		last_row = -1;
		if (rq.req_type == REQ_WRITE) begin
			if (rq.column < COLUMNS && rq.row < ROWS && shadow_cfg.edit_pattern < PATTERNS)
				grid[shadow_cfg.edit_pattern][rq.column][rq.row] = rq.cell_length;
		end else if (rq.column < COLUMNS && shadow_cfg.play_pattern < PATTERNS) begin
			for (int r = 0; r < ROWS; r++)
				if (grid[shadow_cfg.play_pattern][rq.column][r] != 0)
					last_row = r;
			for (int r = 0; r <= last_row; r++) begin
				len = grid[shadow_cfg.play_pattern][rq.column][r];
				if (len != 0) begin
					ev.note_number = NOTE_W'(r + int'(shadow_cfg.transpose));
					ev.note_off    = 1'b0;
					ev.event_time  = rq.timestamp;
					ev.last        = 1'b0;
					note_events.push_back(ev);
					ev.note_off    = 1'b1;
					ev.event_time  = rq.timestamp + TS_W'(longint'(len / 10)
						* longint'(shadow_cfg.note_length));
					ev.last        = (r == last_row);
					note_events.push_back(ev);
				end
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_fire_q      <= 1'b0;
			cfg_fire_q     <= 1'b0;
			requests_taken <= 0;
			for (int p = 0; p < PATTERNS; p++)
				for (int c = 0; c < COLUMNS; c++)
					for (int r = 0; r < ROWS; r++)
						grid[p][c][r] = '0;
			shadow_cfg.play_pattern = '0;
			shadow_cfg.edit_pattern = '0;
			shadow_cfg.transpose    = TRANSPOSE_RESET;
			shadow_cfg.note_length  = NOTE_LEN_RESET;
		end else begin
			in_fire_q  <= in_valid && in_ready;
			cfg_fire_q <= cfg_valid && cfg_ready;
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_PLAY_PATTERN: shadow_cfg.play_pattern = cfg_data[PAT_W-1:0];
					CFG_EDIT_PATTERN: shadow_cfg.edit_pattern = cfg_data[PAT_W-1:0];
					CFG_TRANSPOSE:    shadow_cfg.transpose    = cfg_data[TRANSPOSE_W-1:0];
					CFG_NOTE_LENGTH:  shadow_cfg.note_length  = cfg_data[NOTE_LEN_W-1:0];
					default: ;
				endcase
			end
			if (in_valid && in_ready) begin
				apply_request(in_item);
				requests_taken <= requests_taken + 1;
			end
			if (out_valid && out_ready) begin
				if (note_events.size() == 0) begin
					$error("unexpected result: note_off %0d note_number %0d event_time %0h",
						out_item.note_off, out_item.note_number, out_item.event_time);
					err_count++;
				end else begin
					out_item_t want;
					want = note_events.pop_front();
					if (out_item.note_off !== want.note_off) begin
						$error("note_off: expected %0d, got %0d", want.note_off,
							out_item.note_off);
						err_count++;
					end
					if (out_item.note_number !== want.note_number) begin
						$error("note_number: expected %0d, got %0d", want.note_number,
							out_item.note_number);
						err_count++;
					end
					if (out_item.event_time !== want.event_time) begin
						$error("event_time: expected %0h, got %0h", want.event_time,
							out_item.event_time);
						err_count++;
					end
					if (out_item.last !== want.last) begin
						$error("last: expected %0d, got %0d", want.last, out_item.last);
						err_count++;
					end
				end
			end
		end
	end

	// The sender works in bursts of random length separated by random gaps.
	always @(negedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || in_fire_q) begin
			if (gap_left != 0) begin
				gap_left <= gap_left - 1;
				in_valid <= 1'b0;
			end else if (request_fifo.size() != 0) begin
				in_item  <= request_fifo.pop_front();
				in_valid <= 1'b1;
				if (burst_left <= 1) begin
					burst_left <= $urandom_range(1, 16);
					gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
				end else begin
					burst_left <= burst_left - 1;
				end
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin
		sink_cycle <= sink_cycle + 1;
		case ((sink_cycle / 150) % 4)
			0: out_ready <= 1'b1;
			1: out_ready <= 1'($urandom_range(0, 1));
			2: out_ready <= ($urandom_range(0, 3) == 0);
			default: out_ready <= (sink_cycle % 5) < 3;
		endcase
	end

	task automatic wait_drained();
		do @(negedge clk);
		while (requests_taken != requests_queued || note_events.size() != 0);
		repeat (50) @(negedge clk);
	endtask

	task automatic write_reg(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(negedge clk);
		while (!cfg_fire_q);
	endtask

	task automatic set_phase(input int play, input int edit, input int transp, input int nlen);
		wait_drained();
		write_reg(CFG_PLAY_PATTERN, CFG_DATA_W'(play));
		write_reg(CFG_EDIT_PATTERN, CFG_DATA_W'(edit));
		write_reg(CFG_TRANSPOSE, CFG_DATA_W'(transp));
		write_reg(CFG_NOTE_LENGTH, CFG_DATA_W'(nlen));
		cfg_valid <= 1'b0;
	endtask

	// Most traffic stays inside a narrow band of columns so that steps find notes.
	task automatic queue_random_phase(input int count);
		int                     made;
		int                     base;
		int                     pick;
		bit                     dense;
		logic [COL_FIELD_W-1:0] col;
		made = 0;
		base = $urandom_range(0, COLUMNS - 4);
		while (made < count) begin
			pick = $urandom_range(0, 9);
			col  = ($urandom_range(0, 7) == 0) ? COL_FIELD_W'($urandom)
				: COL_FIELD_W'(base + $urandom_range(0, 3));
			if (pick < 2) begin
				dense = 1'($urandom_range(0, 1));
				for (int r = 0; r < ROWS; r++)
					queue_request(REQ_WRITE, col, ROW_FIELD_W'(r),
						dense ? CELL_W'($urandom_range(1, 1023)) : rand_length(),
						TS_W'($urandom));
				made += ROWS;
				repeat ($urandom_range(1, 3)) begin
					queue_request(REQ_STEP, col, ROW_FIELD_W'($urandom),
						CELL_W'($urandom), rand_stamp());
					made++;
				end
			end else if (pick < 6) begin
				queue_request(REQ_WRITE, col,
					($urandom_range(0, 4) == 0) ? ROW_FIELD_W'($urandom)
						: ROW_FIELD_W'($urandom_range(0, ROWS - 1)),
					rand_length(), TS_W'($urandom));
				made++;
			end else begin
				queue_request(REQ_STEP, col, ROW_FIELD_W'($urandom), CELL_W'($urandom),
					rand_stamp());
				made++;
			end
		end
	endtask

	initial begin
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		queue_request(REQ_STEP, 0, 0, 0, 0);
		queue_request(REQ_WRITE, 0, 0, 10'd1023, 0);
		queue_request(REQ_WRITE, 0, 19, 10'd5, 32'hFFFF_FFFF);
		queue_request(REQ_WRITE, 0, 20, 10'd7, 0);
		queue_request(REQ_WRITE, 0, 31, 10'd1, 0);
		queue_request(REQ_WRITE, 0, 10, 10'd9, 0);
		queue_request(REQ_WRITE, 0, 10, 10'd0, 0);
		queue_request(REQ_WRITE, 31, 10, 10'd10, 0);
		queue_request(REQ_WRITE, 31, 0, 10'd1, 0);
		queue_request(REQ_STEP, 0, 31, 10'd1023, 32'hFFFF_FFF0);
		queue_request(REQ_STEP, 31, 0, 0, 0);
		queue_request(REQ_STEP, 31, 0, 0, 32'hFFFF_FFFF);
		queue_request(REQ_STEP, 5, 0, 0, 32'h1234_5678);
		queue_request(REQ_STEP, 0, 0, 0, 0);
		queue_random_phase(55);

		set_phase(15, 15, 127, 1048575);
		queue_random_phase(55);
		set_phase(15, 3, 0, 0);
		queue_random_phase(55);
		set_phase(3, 3, 64, 1);
		queue_random_phase(55);
		set_phase(7, 7, 127, $urandom_range(0, 1048575));
		queue_random_phase(55);
		set_phase(0, 15, $urandom_range(0, 127), $urandom_range(0, 1048575));
		queue_random_phase(55);

		wait_drained();
		if (err_count == 0)
			$display("pattern_step_sequencer_top_tb: clean");
		else
			$display("pattern_step_sequencer_top_tb: errors");
		$finish;
	end

	initial begin
		#(600000 * 12);
		$display("pattern_step_sequencer_top_tb: errors");
		$finish;
	end

endmodule
